FILE: rtl/v2c_pkg.sv
// v2c_pkg: shared types, widths, register codes and the axis clamp function
// for the vol2col patch address generator. Depends on nothing.
`default_nettype none

package v2c_pkg;

  // Default kernel extents
  localparam int KT_DEF = 3;
  localparam int KH_DEF = 3;
  localparam int KW_DEF = 3;

  // Position queue depth between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Field and datapath widths
  localparam int POS_W     = 10;
  localparam int ROW_W     = 28;
  localparam int TAP_W     = 6;
  localparam int DEPTH_W   = 9;
  localparam int SIZE_W    = 11;
  localparam int PAD_W     = 2;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 12;
  localparam int AT_W      = DEPTH_W;
  localparam int HW_W      = 2 * SIZE_W;
  localparam int P1_W      = AT_W + HW_W;
  localparam int P2_W      = 2 * SIZE_W;

  // Register reset values
  localparam logic [DEPTH_W-1:0] DEPTH_RST  = DEPTH_W'(16);
  localparam logic [SIZE_W-1:0]  HEIGHT_RST = SIZE_W'(16);
  localparam logic [SIZE_W-1:0]  WIDTH_RST  = SIZE_W'(16);
  localparam logic [PAD_W-1:0]   PAD_RST    = PAD_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_IN   = 3'd0,
    REG_HEIGHT_IN  = 3'd1,
    REG_WIDTH_IN   = 3'd2,
    REG_PAD_DEPTH  = 3'd3,
    REG_PAD_HEIGHT = 3'd4,
    REG_PAD_WIDTH  = 3'd5,
    REG_ZERO_MODE  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0] t;
    logic [POS_W-1:0] h;
    logic [POS_W-1:0] w;
  } pos_t;

  // Queue head as seen by the tap sequencer
  typedef struct packed {
    logic vld;
    pos_t pos;
  } head_t;

  // One classified tap request leaving the sequencer
  typedef struct packed {
    logic              vld;
    logic [AT_W-1:0]   at;
    logic [SIZE_W-1:0] ah;
    logic [SIZE_W-1:0] aw;
    logic              fill;
    logic [TAP_W-1:0]  tap;
    logic              last;
  } tap_req_t;

  typedef struct packed {
    logic              outside;
    logic [SIZE_W-1:0] val;
  } axis_t;

  // Clamp a signed coordinate into [0, size-1] and flag whether it was outside
  function automatic axis_t axis_fix(input logic [COORD_W-1:0] coord,
                                     input logic [SIZE_W-1:0] size);
    axis_t r;
    r.outside = 1'b0;
    r.val     = coord[SIZE_W-1:0];
    if (coord[COORD_W-1] || (size == '0)) begin
      r.outside = 1'b1;
      r.val     = '0;
    end else if (coord[SIZE_W-1:0] >= size) begin
      r.outside = 1'b1;
      r.val     = size - SIZE_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vol2col_patch_address_gen_unit.sv
// vol2col_patch_address_gen_unit: configuration registers and the top-level
// wiring of the 3D patch gather address generator.
// Depends on v2c_pkg, v2c_front, v2c_tap_seq and v2c_addr_pipe.
//
// Usage: each input transfer carries one output position (t, h, w). For it the
// block emits KT*KH*KW gather requests, in kt, kh, kw order, on the result
// channel: a flattened input row index or a zero-fill marker, the tap number
// and a last flag on the final tap. Both channels use valid/stall; a transfer
// happens on a clock edge with valid high and stall low.
// Throughput: the tap sequencer issues one request per cycle while out_stall
// does not freeze it; a position has KT*KH*KW requests (27 with the default
// 3x3x3 kernel). A two-entry position queue sits in front, so following
// positions are taken while the current one is still being walked.
// Path: a position passes the queue, the sequencer's request register, the
// multiply stage and the result register before its first request is valid.
// Stalls: out_stall freezes the sequencer, the multiply and sum stages and the
// result register together; the queue keeps taking positions until full.
// Reset: synchronous, active low; queue and pipeline empty, registers return
// to 16x16x16 volume, padding 1, zero mode. Configuration is written through
// cfg_wr_en/cfg_index/cfg_wdata; the user must write it only while the block
// is idle, which the block does not enforce; unknown indices are ignored.
`default_nettype none

module vol2col_patch_address_gen_unit
  import v2c_pkg::*;
#(
  parameter int KT = KT_DEF,
  parameter int KH = KH_DEF,
  parameter int KW = KW_DEF
)
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [POS_W-1:0]     in_out_t,
  input  wire logic [POS_W-1:0]     in_out_h,
  input  wire logic [POS_W-1:0]     in_out_w,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ROW_W-1:0]          out_row_index,
  output logic                      out_fill_zero,
  output logic [TAP_W-1:0]          out_tap,
  output logic                      out_last
);

  localparam int TAPS = KT * KH * KW;

  logic [DEPTH_W-1:0] depth_r;
  logic [SIZE_W-1:0]  height_r;
  logic [SIZE_W-1:0]  width_r;
  logic [PAD_W-1:0]   pad_d_r;
  logic [PAD_W-1:0]   pad_h_r;
  logic [PAD_W-1:0]   pad_w_r;
  logic               zero_mode_r;
  logic [HW_W-1:0]    hw_r;

  head_t    head;
  logic     pop;
  logic     advance;
  tap_req_t req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= DEPTH_RST;
      height_r    <= HEIGHT_RST;
      width_r     <= WIDTH_RST;
      pad_d_r     <= PAD_RST;
      pad_h_r     <= PAD_RST;
      pad_w_r     <= PAD_RST;
      zero_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEPTH_IN:   depth_r     <= cfg_wdata[DEPTH_W-1:0];
        REG_HEIGHT_IN:  height_r    <= cfg_wdata[SIZE_W-1:0];
        REG_WIDTH_IN:   width_r     <= cfg_wdata[SIZE_W-1:0];
        REG_PAD_DEPTH:  pad_d_r     <= cfg_wdata[PAD_W-1:0];
        REG_PAD_HEIGHT: pad_h_r     <= cfg_wdata[PAD_W-1:0];
        REG_PAD_WIDTH:  pad_w_r     <= cfg_wdata[PAD_W-1:0];
        REG_ZERO_MODE:  zero_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Frame size in rows, registered from the height and width registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= HW_W'(HEIGHT_RST) * HW_W'(WIDTH_RST);
    end else begin
      hw_r <= HW_W'(height_r) * HW_W'(width_r);
    end
  end

  v2c_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_out_t (in_out_t),
    .in_out_h (in_out_h),
    .in_out_w (in_out_w),
    .pop      (pop),
    .head     (head)
  );

  v2c_tap_seq #(
    .KT (KT),
    .KH (KH),
    .KW (KW)
  ) u_tap_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .head       (head),
    .pop        (pop),
    .depth_in   (depth_r),
    .height_in  (height_r),
    .width_in   (width_r),
    .pad_depth  (pad_d_r),
    .pad_height (pad_h_r),
    .pad_width  (pad_w_r),
    .zero_mode  (zero_mode_r),
    .req        (req)
  );

  v2c_addr_pipe u_addr_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req),
    .hw            (hw_r),
    .width_in      (width_r),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_fill_zero (out_fill_zero),
    .out_tap       (out_tap),
    .out_last      (out_last)
  );

`ifndef SYNTH
  a_last_tap : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_tap == TAP_W'(TAPS - 1))
    else $error("last flag on a tap other than the final one");

  a_fill_row : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_zero |-> out_row_index == '0)
    else $error("zero-fill request carries a non-zero row index");

  a_pop_head : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.vld && advance)
    else $error("queue popped without a live head");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");
`endif

endmodule

`default_nettype wire

FILE: rtl/v2c_front.sv
// v2c_front: input acceptance and a short position queue feeding the back end.
// Depends on v2c_pkg.
`default_nettype none

module v2c_front
  import v2c_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [POS_W-1:0] in_out_t,
  input  wire logic [POS_W-1:0] in_out_h,
  input  wire logic [POS_W-1:0] in_out_w,
  input  wire logic             pop,
  output head_t                 head
);

  pos_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              do_pop;

  assign in_stall = (cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (cnt_r != '0);

  assign head.vld = (cnt_r != '0);
  assign head.pos = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{t: in_out_t, h: in_out_h, w: in_out_w};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/v2c_tap_seq.sv
// v2c_tap_seq: walks the kernel taps of the queue head, forms and clamps the
// input coordinates and registers one classified request per cycle while the back end advances.
// Depends on v2c_pkg.
`default_nettype none

module v2c_tap_seq
  import v2c_pkg::*;
#(
  parameter int KT = KT_DEF,
  parameter int KH = KH_DEF,
  parameter int KW = KW_DEF
)
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  head_t                   head,
  output logic                    pop,
  input  wire logic [DEPTH_W-1:0] depth_in,
  input  wire logic [SIZE_W-1:0]  height_in,
  input  wire logic [SIZE_W-1:0]  width_in,
  input  wire logic [PAD_W-1:0]   pad_depth,
  input  wire logic [PAD_W-1:0]   pad_height,
  input  wire logic [PAD_W-1:0]   pad_width,
  input  wire logic               zero_mode,
  output tap_req_t                req
);

  localparam int KT_W = (KT > 1) ? $clog2(KT) : 1;
  localparam int KH_W = (KH > 1) ? $clog2(KH) : 1;
  localparam int KW_W = (KW > 1) ? $clog2(KW) : 1;

  logic [KT_W-1:0]  kt_r, kt_nxt;
  logic [KH_W-1:0]  kh_r, kh_nxt;
  logic [KW_W-1:0]  kw_r, kw_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;
  logic             vld_r;
  tap_req_t         req_r;
  logic             take;
  logic             kt_end, kh_end, kw_end, last_tap;
  logic [COORD_W-1:0] ct, ch, cw;
  axis_t            ax_t, ax_h, ax_w;

  assign kt_end   = (kt_r == KT_W'(KT - 1));
  assign kh_end   = (kh_r == KH_W'(KH - 1));
  assign kw_end   = (kw_r == KW_W'(KW - 1));
  assign last_tap = kt_end && kh_end && kw_end;

  assign take = advance && head.vld;
  assign pop  = take && last_tap;

  assign ct = COORD_W'(head.pos.t) + COORD_W'(kt_r) - COORD_W'(pad_depth);
  assign ch = COORD_W'(head.pos.h) + COORD_W'(kh_r) - COORD_W'(pad_height);
  assign cw = COORD_W'(head.pos.w) + COORD_W'(kw_r) - COORD_W'(pad_width);

  assign ax_t = axis_fix(ct, SIZE_W'(depth_in));
  assign ax_h = axis_fix(ch, height_in);
  assign ax_w = axis_fix(cw, width_in);

  // Advance the tap counters, kw innermost
  always_comb begin
    kt_nxt  = kt_r;
    kh_nxt  = kh_r;
    kw_nxt  = kw_r;
    tap_nxt = tap_r;
    if (take) begin
      tap_nxt = last_tap ? '0 : tap_r + TAP_W'(1);
      kw_nxt  = kw_end ? '0 : kw_r + KW_W'(1);
      if (kw_end) begin
        kh_nxt = kh_end ? '0 : kh_r + KH_W'(1);
        if (kh_end) begin
          kt_nxt = kt_end ? '0 : kt_r + KT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kt_r  <= '0;
      kh_r  <= '0;
      kw_r  <= '0;
      tap_r <= '0;
      vld_r <= 1'b0;
    end else begin
      kt_r  <= kt_nxt;
      kh_r  <= kh_nxt;
      kw_r  <= kw_nxt;
      tap_r <= tap_nxt;
      if (advance) begin
        vld_r <= head.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r.vld  <= 1'b1;
      req_r.at   <= ax_t.val[AT_W-1:0];
      req_r.ah   <= ax_h.val;
      req_r.aw   <= ax_w.val;
      req_r.fill <= (ax_t.outside || ax_h.outside || ax_w.outside) && zero_mode;
      req_r.tap  <= tap_r;
      req_r.last <= last_tap;
    end
  end

  always_comb begin
    req     = req_r;
    req.vld = vld_r;
  end

endmodule

`default_nettype wire

FILE: rtl/v2c_addr_pipe.sv
// v2c_addr_pipe: turns clamped coordinates into the flattened row index over
// a multiply stage and a sum stage, and holds the result register.
// Depends on v2c_pkg.
`default_nettype none

module v2c_addr_pipe
  import v2c_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  tap_req_t               req,
  input  wire logic [HW_W-1:0]   hw,
  input  wire logic [SIZE_W-1:0] width_in,
  output logic                   advance,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ROW_W-1:0]       out_row_index,
  output logic                   out_fill_zero,
  output logic [TAP_W-1:0]       out_tap,
  output logic                   out_last
);

  logic              s2_vld_r;
  logic [P1_W-1:0]   p1_r;
  logic [P2_W-1:0]   p2_r;
  logic [SIZE_W-1:0] aw_r;
  logic              fill_r;
  logic [TAP_W-1:0]  tap_r;
  logic              last_r;

  logic              out_vld_r;
  logic [ROW_W-1:0]  row_r;
  logic              ofill_r;
  logic [TAP_W-1:0]  otap_r;
  logic              olast_r;
  logic [ROW_W-1:0]  row_sum;

  // The whole back pipeline moves when the result register is free or taken
  assign advance = !out_vld_r || !out_stall;

  assign row_sum = p1_r[ROW_W-1:0] + ROW_W'(p2_r) + ROW_W'(aw_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      s2_vld_r  <= req.vld;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_r    <= P1_W'(req.at) * P1_W'(hw);
      p2_r    <= P2_W'(req.ah) * P2_W'(width_in);
      aw_r    <= req.aw;
      fill_r  <= req.fill;
      tap_r   <= req.tap;
      last_r  <= req.last;
      row_r   <= fill_r ? '0 : row_sum;
      ofill_r <= fill_r;
      otap_r  <= tap_r;
      olast_r <= last_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_row_index = row_r;
  assign out_fill_zero = ofill_r;
  assign out_tap       = otap_r;
  assign out_last      = olast_r;

endmodule

`default_nettype wire

FILE: tb/tb_vol2col_patch_address_gen_unit.sv
// Self-checking testbench for vol2col_patch_address_gen_unit: predicts every gather request of
// each output position from a shadow copy of the registers and checks requests in order.
// Depends on v2c_pkg and the RTL of the unit; needs no files or arguments at run time.
module tb_vol2col_patch_address_gen_unit
  import v2c_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TAPS     = KT_DEF * KH_DEF * KW_DEF;
  localparam int GAP_MAX      = 13;
  localparam int IDLE_CYCLES  = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 26;
  localparam int RUN_LIMIT_NS = 1_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic             fill_zero;
    logic [TAP_W-1:0] tap;
    logic             last;
  } gather_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [POS_W-1:0]     in_out_t;
  logic [POS_W-1:0]     in_out_h;
  logic [POS_W-1:0]     in_out_w;
  logic                 out_valid;
  logic                 out_stall;
  logic [ROW_W-1:0]     out_row_index;
  logic                 out_fill_zero;
  logic [TAP_W-1:0]     out_tap;
  logic                 out_last;

  // Shadow of the configuration registers
  logic [DEPTH_W-1:0] vol_depth;
  logic [SIZE_W-1:0]  vol_height;
  logic [SIZE_W-1:0]  vol_width;
  logic [PAD_W-1:0]   pad_t;
  logic [PAD_W-1:0]   pad_h;
  logic [PAD_W-1:0]   pad_w;
  logic               zero_pad;

  gather_req_t gather_reqs_due[$];
  int          mismatch_count = 0;
  bit          in_no_gaps     = 1'b0;
  bit          out_no_stall   = 1'b0;

  vol2col_patch_address_gen_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_out_t      (in_out_t),
    .in_out_h      (in_out_h),
    .in_out_w      (in_out_w),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_fill_zero (out_fill_zero),
    .out_tap       (out_tap),
    .out_last      (out_last)
  );

  always #1 clk = ~clk;

  // Clamp one axis into [0, size-1]; flag coordinates that fall outside
  function automatic bit clamp_axis(input int coord, input int size,
                                    output longint unsigned val);
    if (coord < 0 || size == 0) begin
      val = 0;
      return 1'b1;
    end
    if (coord > size - 1) begin
      val = size - 1;
      return 1'b1;
    end
    val = coord;
    return 1'b0;
  endfunction

  function automatic void predict_patch_reqs(input logic [POS_W-1:0] pt, ph, pw);
    longint unsigned at, ah, aw, row;
    bit              ot, oh, ow, fill;
    int              n;
    gather_req_t     req;
    n = 0;
    for (int kt = 0; kt < KT_DEF; kt++) begin
      for (int kh = 0; kh < KH_DEF; kh++) begin
        for (int kw = 0; kw < KW_DEF; kw++) begin
          ot   = clamp_axis(int'(pt) + kt - int'(pad_t), int'(vol_depth), at);
          oh   = clamp_axis(int'(ph) + kh - int'(pad_h), int'(vol_height), ah);
          ow   = clamp_axis(int'(pw) + kw - int'(pad_w), int'(vol_width), aw);
          fill = (ot || oh || ow) && zero_pad;
          row  = fill ? 64'd0 : at * vol_height * vol_width + ah * vol_width + aw;
          req.row_index = row[ROW_W-1:0];
          req.fill_zero = fill;
          req.tap       = TAP_W'(n);
          req.last      = (n == NUM_TAPS - 1);
          gather_reqs_due.push_back(req);
          n++;
        end
      end
    end
  endfunction

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : int'($urandom_range(0, GAP_MAX));
  endfunction

  // Coordinate near the low edge, near the far edge of the volume, or anywhere
  function automatic logic [POS_W-1:0] pick_coord(input int size);
    int v;
    case ($urandom_range(0, 2))
      0:       v = int'($urandom_range(0, 5));
      1:       v = size - 4 + int'($urandom_range(0, 7));
      default: v = int'($urandom_range(0, 1023));
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return POS_W'(v);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_DEPTH_IN:   vol_depth  = value[DEPTH_W-1:0];
      REG_HEIGHT_IN:  vol_height = value[SIZE_W-1:0];
      REG_WIDTH_IN:   vol_width  = value[SIZE_W-1:0];
      REG_PAD_DEPTH:  pad_t      = value[PAD_W-1:0];
      REG_PAD_HEIGHT: pad_h      = value[PAD_W-1:0];
      REG_PAD_WIDTH:  pad_w      = value[PAD_W-1:0];
      REG_ZERO_MODE:  zero_pad   = value[0];
      default: ; // unmapped index: the block drops the write
    endcase
  endtask

  task automatic configure_volume(input logic [CFG_W-1:0] d, h, w, p_t, p_h, p_w, zm);
    write_reg(REG_DEPTH_IN, d);
    write_reg(REG_HEIGHT_IN, h);
    write_reg(REG_WIDTH_IN, w);
    write_reg(REG_PAD_DEPTH, p_t);
    write_reg(REG_PAD_HEIGHT, p_h);
    write_reg(REG_PAD_WIDTH, p_w);
    write_reg(REG_ZERO_MODE, zm);
  endtask

  // One position transfer; valid stays high afterwards until the next call decides
  task automatic send_position(input logic [POS_W-1:0] t, h, w);
    int gap;
    gap = draw_wait(in_no_gaps);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_out_t <= t;
    in_out_h <= h;
    in_out_w <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_patch_reqs(t, h, w);
  endtask

  // Hold the sender until every predicted request has been seen
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (gather_reqs_due.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(negedge clk);
  endtask

  task automatic test_reset_volume();
    send_position(10'd0, 10'd0, 10'd0);
    send_position(10'd15, 10'd15, 10'd15);
    send_position(10'd1023, 10'd1023, 10'd1023);
    send_position(10'd1, 10'd1, 10'd1);
    send_position(10'd16, 10'd7, 10'd0);
  endtask

  task automatic test_replicate_clamp();
    wait_results_drained();
    configure_volume(11'd16, 11'd16, 11'd16, 11'd3, 11'd3, 11'd3, 11'd0);
    send_position(10'd0, 10'd0, 10'd0);
    send_position(10'd1023, 10'd1023, 10'd1023);
    send_position(10'd15, 10'd0, 10'd8);
    wait_results_drained();
    configure_volume(11'd16, 11'd16, 11'd16, 11'd0, 11'd0, 11'd0, 11'd0);
    send_position(10'd0, 10'd0, 10'd0);
    send_position(10'd14, 10'd14, 10'd14);
  endtask

  task automatic test_empty_axis();
    wait_results_drained();
    configure_volume(11'd0, 11'd16, 11'd16, 11'd1, 11'd1, 11'd1, 11'd1);
    send_position(10'd0, 10'd0, 10'd0);
    wait_results_drained();
    configure_volume(11'd4, 11'd0, 11'd0, 11'd2, 11'd1, 11'd0, 11'd0);
    send_position(10'd3, 10'd3, 10'd3);
    send_position(10'd1023, 10'd0, 10'd1023);
  endtask

  // Sizes beyond the stated ranges push the row index past its width
  task automatic test_wide_row_index();
    wait_results_drained();
    configure_volume(11'h7FF, 11'h7FF, 11'h7FF, 11'd0, 11'd0, 11'd0, 11'd0);
    send_position(10'd1023, 10'd1023, 10'd1023);
    send_position(10'd600, 10'd100, 10'd50);
  endtask

  task automatic test_unknown_register();
    wait_results_drained();
    configure_volume(11'd8, 11'd8, 11'd8, 11'd1, 11'd1, 11'd1, 11'd1);
    write_reg(REG_UNMAPPED, 11'h7FF);
    send_position(10'd7, 10'd0, 10'd4);
  endtask

  task automatic test_random_positions();
    int d, h, w, mode;
    for (int phase = 0; phase < PHASES; phase++) begin
      mode = (phase == 0) ? 0 : (phase == 1) ? 3 : int'($urandom_range(0, 5));
      case (mode)
        0: begin d = 1; h = 1; w = 1; end
        1: begin
          d = $urandom_range(1, 6); h = $urandom_range(1, 6); w = $urandom_range(1, 6);
        end
        2: begin
          d = $urandom_range(1, 256); h = $urandom_range(1, 1024); w = $urandom_range(1, 1024);
        end
        3: begin d = 256; h = 1024; w = 1024; end
        4: begin
          d = $urandom_range(0, 2047); h = $urandom_range(0, 2047); w = $urandom_range(0, 2047);
        end
        default: begin
          d = $urandom_range(1, 4); h = $urandom_range(1, 4); w = $urandom_range(1, 4);
          case ($urandom_range(0, 2))
            0:       d = 0;
            1:       h = 0;
            default: w = 0;
          endcase
        end
      endcase
      wait_results_drained();
      // raw random data also exercises the masking of narrow registers
      if (mode == 4)
        configure_volume(CFG_W'(d), CFG_W'(h), CFG_W'(w), CFG_W'($urandom_range(0, 2047)),
                         CFG_W'($urandom_range(0, 2047)), CFG_W'($urandom_range(0, 2047)),
                         CFG_W'($urandom_range(0, 2047)));
      else
        configure_volume(CFG_W'(d), CFG_W'(h), CFG_W'(w), CFG_W'($urandom_range(0, 3)),
                         CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 3)),
                         CFG_W'($urandom_range(0, 1)));
      in_no_gaps   = ($urandom_range(0, 3) == 0);
      out_no_stall = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 24) == 0) wait_results_drained();
        send_position(pick_coord(vol_depth), pick_coord(vol_height), pick_coord(vol_width));
      end
    end
    in_no_gaps   = 1'b0;
    out_no_stall = 1'b0;
  endtask

  // Result side: stall for a random number of cycles ahead of each transfer (none while out_no_stall is set)
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = draw_wait(out_no_stall);
      repeat (hold) begin
        out_stall <= 1'b1;
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : req_checker
    gather_req_t exp_req;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (gather_reqs_due.size() == 0) begin
        $display("%0t: unexpected request row %0h fill %0b tap %0d last %0b", $time,
                 out_row_index, out_fill_zero, out_tap, out_last);
        mismatch_count++;
      end else begin
        exp_req = gather_reqs_due.pop_front();
        if (out_row_index !== exp_req.row_index) begin
          $display("%0t: row_index expected %0h actual %0h", $time,
                   exp_req.row_index, out_row_index);
          mismatch_count++;
        end
        if (out_fill_zero !== exp_req.fill_zero) begin
          $display("%0t: fill_zero expected %0b actual %0b", $time,
                   exp_req.fill_zero, out_fill_zero);
          mismatch_count++;
        end
        if (out_tap !== exp_req.tap) begin
          $display("%0t: tap expected %0d actual %0d", $time, exp_req.tap, out_tap);
          mismatch_count++;
        end
        if (out_last !== exp_req.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_req.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("vol2col_patch_address_gen_unit verification failed");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_out_t   = '0;
    in_out_h   = '0;
    in_out_w   = '0;
    vol_depth  = DEPTH_RST;
    vol_height = HEIGHT_RST;
    vol_width  = WIDTH_RST;
    pad_t      = PAD_RST;
    pad_h      = PAD_RST;
    pad_w      = PAD_RST;
    zero_pad   = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_volume();
    test_replicate_clamp();
    test_empty_axis();
    test_wide_row_index();
    test_unknown_register();
    test_random_positions();
    wait_results_drained();

    if (mismatch_count == 0)
      $display("vol2col_patch_address_gen_unit verification clean");
    else
      $display("vol2col_patch_address_gen_unit verification failed");
    $finish;
  end

endmodule
